/* rtl/url_percent_decoder_macros.svh */
// ----------------------------------------------------------------------------
// url_percent_decoder_macros.svh
// Assertion macros shared by the URL percent decoder modules. Each macro
// expects a clock named clk and a synchronous reset named rst in scope.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/upd_pkg.sv */
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and the hex digit helper of the URL percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_F  = 8'h46;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_F  = 8'h66;
  localparam logic [3:0] HEX_ALPHA_BASE = 4'hA;

  // Escape sequencer states.
  localparam logic [1:0] ESC_IDLE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  // Register addresses (word index) and reset values.
  localparam logic REG_QUERY_MODE = 1'b0;
  localparam logic QUERY_MODE_RESET = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } src_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       decode_failed;
  } dst_word_t;

  typedef struct packed {
    logic wr;
    logic value;
  } cfg_wr_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nibble;
  } hex_t;

  // Classifies a byte as a hex digit; bad is set for anything else.
  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t       h;
    logic [7:0] d;
    h.bad = 1'b0;
    h.nibble = 4'h0;
    d = 8'h00;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = b - CH_ZERO;
      h.nibble = d[3:0];
    end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
      d = b - CH_UPPER_A;
      h.nibble = d[3:0] + HEX_ALPHA_BASE;
    end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
      d = b - CH_LOWER_A;
      h.nibble = d[3:0] + HEX_ALPHA_BASE;
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* rtl/upd_apb.sv */
// ----------------------------------------------------------------------------
// upd_apb
// APB register port holding the query mode start setting.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_apb import upd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_wr_t          cfg,
  output logic             query_start
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_QUERY_MODE);

  assign cfg.wr    = psel && penable && pwrite && hit;
  assign cfg.value = pwdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      query_start <= QUERY_MODE_RESET;
    end else if (cfg.wr) begin
      query_start <= cfg.value;
    end
  end

  assign prdata = hit ? {31'b0, query_start} : 32'b0;

endmodule

`default_nettype wire

/* rtl/upd_core.sv */
// ----------------------------------------------------------------------------
// upd_core
// Per-string decode state and the decode step that turns one raw byte
// into at most one decoded result.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_core import upd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire src_word_t word,
  input  wire cfg_wr_t   cfg,
  input  wire logic      query_start,
  output dst_word_t      result,
  output logic           has_result
);

  logic       query_mode, query_mode_next;
  logic [1:0] esc, esc_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       first_bad, first_bad_next;
  logic       failed, failed_next;
  logic       stopped, stopped_next;
  logic       mid_string;
  logic [7:0] ob;
  logic       ob_valid;
  hex_t       hx;
  logic [7:0] decoded;

  assign hx      = hex_value(word.in_byte);
  assign decoded = {high_nibble, hx.nibble};

  always_comb begin
    query_mode_next  = query_mode;
    esc_next         = esc;
    high_nibble_next = high_nibble;
    first_bad_next   = first_bad;
    failed_next      = failed;
    stopped_next     = stopped;
    ob               = 8'h00;
    ob_valid         = 1'b0;
    if (!stopped) begin
      if (word.in_byte == 8'h00) begin
        stopped_next = 1'b1;
        esc_next     = ESC_IDLE;
      end else begin
        unique case (esc)
          ESC_PCT: begin
            first_bad_next   = hx.bad;
            high_nibble_next = hx.nibble;
            esc_next         = ESC_DIGIT;
          end
          ESC_DIGIT: begin
            esc_next = ESC_IDLE;
            if (first_bad || hx.bad) begin
              failed_next  = 1'b1;
              stopped_next = 1'b1;
            end else if (decoded == 8'h00) begin
              stopped_next = 1'b1;
            end else begin
              ob       = decoded;
              ob_valid = 1'b1;
            end
          end
          default: begin
            if (word.in_byte == CH_PERCENT) begin
              esc_next = ESC_PCT;
            end else if (query_mode && word.in_byte == CH_PLUS) begin
              ob       = CH_SPACE;
              ob_valid = 1'b1;
            end else begin
              if (word.in_byte == CH_QUESTION) begin
                query_mode_next = 1'b1;
              end
              ob       = word.in_byte;
              ob_valid = 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign has_result           = ob_valid || word.last_byte;
  assign result.out_byte      = ob;
  assign result.byte_valid    = ob_valid;
  assign result.string_done   = word.last_byte;
  assign result.decode_failed = word.last_byte && failed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_mode  <= QUERY_MODE_RESET;
      esc         <= ESC_IDLE;
      high_nibble <= 4'h0;
      first_bad   <= 1'b0;
      failed      <= 1'b0;
      stopped     <= 1'b0;
      mid_string  <= 1'b0;
    end else if (step) begin
      if (word.last_byte) begin
        query_mode  <= query_start;
        esc         <= ESC_IDLE;
        high_nibble <= 4'h0;
        first_bad   <= 1'b0;
        failed      <= 1'b0;
        stopped     <= 1'b0;
        mid_string  <= 1'b0;
      end else begin
        query_mode  <= query_mode_next;
        esc         <= esc_next;
        high_nibble <= high_nibble_next;
        first_bad   <= first_bad_next;
        failed      <= failed_next;
        stopped     <= stopped_next;
        mid_string  <= 1'b1;
      end
    end else if (cfg.wr && !mid_string) begin
      query_mode <= cfg.value;
    end
  end

endmodule

`default_nettype wire

/* rtl/url_percent_decoder.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder
// Timing: an accepted word is held in the input register, decoded there, and
//   its result, if any, is loaded into the output register behind dst_word.
// Throughput: one word per cycle unless dst_stall holds back a result.
// Reset: synchronous, active high; clears all string state and loads query
//   mode at start with one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "url_percent_decoder_macros.svh"

module url_percent_decoder import upd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // Encoded byte stream.
  input  wire logic        src_valid,
  output logic             src_stall,
  input  wire src_word_t   src_word,
  // Decoded result stream.
  output logic             dst_valid,
  input  wire logic        dst_stall,
  output dst_word_t        dst_word,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // The input register holds one accepted word until the decode step can
  // retire it. A word that yields no result retires straight away; one that
  // does yields only when the output register is free or is being emptied.
  // The input side therefore stalls only when both registers are occupied
  // and the result cannot move on.

  src_word_t s1_word;
  logic      s1_valid;
  logic      s1_step;
  logic      out_free;
  logic      has_result;
  dst_word_t result;
  cfg_wr_t   cfg;
  logic      query_start;
  logic      src_accept;

  upd_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg         (cfg),
    .query_start (query_start)
  );

  upd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_step),
    .word        (s1_word),
    .cfg         (cfg),
    .query_start (query_start),
    .result      (result),
    .has_result  (has_result)
  );

  assign out_free   = !dst_valid || !dst_stall;
  assign s1_step    = s1_valid && (!has_result || out_free);
  assign src_stall  = s1_valid && !s1_step;
  assign src_accept = src_valid && !src_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_accept) begin
      s1_word <= src_word;
    end
  end

  // Output register: loaded with each result, held while the far side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (s1_step && has_result) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && has_result) begin
      dst_word <= result;
    end
  end

  // A result must never overwrite one that is still waiting to be taken.
  `UPD_ASSERT_NOW(a_no_overwrite, s1_step && has_result, out_free, "result overwritten")
  // A decode step with a result leaves a valid word in the output register.
  `UPD_ASSERT_NEXT(a_result_lands, s1_step && has_result, dst_valid, "result lost")
  // A failure flag only ever travels on the closing word of a string.
  `UPD_ASSERT_NOW(a_fail_on_done, dst_valid && dst_word.decode_failed, dst_word.string_done, "failure flag without string end")

endmodule

`default_nettype wire
